### rtl/dcf_pkg.sv
// Package for the duplicate-free coordinate queue.
// Holds operation and status codes, field widths and the cell control struct.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package dcf_pkg;

    localparam int DCF_QUEUE_DEPTH = 64;
    localparam int DCF_COORD_WIDTH = 8;
    localparam int DCF_FIELD_W     = 8;
    localparam int DCF_CNT_W       = $clog2(DCF_QUEUE_DEPTH + 1);
    localparam int DCF_SCAN_CHUNK  = 32;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_POP      = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic cmp;
        logic load;
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

`default_nettype wire

### rtl/dcf_if.sv
// Request and result channel interfaces of the coordinate queue.
// Depends on dcf_pkg for the operation and status types.
`default_nettype none

interface dcf_req_if
    import dcf_pkg::*;
;
    logic                   valid;
    logic                   ready;
    t_op                    operation;
    logic [DCF_FIELD_W-1:0] coord_x;
    logic [DCF_FIELD_W-1:0] coord_y;

    modport source (output valid, output operation, output coord_x, output coord_y,
                    input ready);
    modport sink   (input valid, input operation, input coord_x, input coord_y,
                    output ready);
endinterface

interface dcf_res_if
    import dcf_pkg::*;
#(
    parameter int CNT_W = DCF_CNT_W
);
    logic                   valid;
    logic                   ready;
    t_status                status;
    logic                   found;
    logic [DCF_FIELD_W-1:0] popped_x;
    logic [DCF_FIELD_W-1:0] popped_y;
    logic [CNT_W-1:0]       entry_count;
    logic                   is_empty;

    modport source (output valid, output status, output found, output popped_x,
                    output popped_y, output entry_count, output is_empty,
                    input ready);
    modport sink   (input valid, input status, input found, input popped_x,
                    input popped_y, input entry_count, input is_empty,
                    output ready);
endinterface

`default_nettype wire

### rtl/dcf_cell.sv
// One storage cell of the queue chain: a valid bit, a stored pair and a match flag.
// Depends on dcf_pkg for the control struct; neighbours feed it on every cycle.
`default_nettype none

module dcf_cell
    import dcf_pkg::*;
#(
    parameter int KEY_W = 2 * DCF_COORD_WIDTH
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  t_cell_ctrl      i_ctrl,
    input  wire [KEY_W-1:0] i_key,
    input  wire             i_prev_valid,
    input  wire             i_next_valid,
    input  wire [KEY_W-1:0] i_next_data,
    output logic            o_valid,
    output logic [KEY_W-1:0] o_data,
    output logic            o_hit
);

    logic             r_valid, n_valid;
    logic [KEY_W-1:0] r_data, n_data;
    logic             r_hit;

    // The first free cell above an occupied one takes a new pair; on a pop
    // every cell copies its upper neighbour so the head stays in cell zero.
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        priority if (i_ctrl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctrl.shift) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
        end else if (i_ctrl.load && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_data  = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_ctrl.cmp) begin
                r_hit <= r_valid && (r_data == i_key);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

### rtl/dcf_scan.sv
// Folds the per-cell match flags into a single hit, one chunk of flags a cycle.
// Depends on dcf_pkg for the chunk width.
`default_nettype none

module dcf_scan
    import dcf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DCF_QUEUE_DEPTH
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire [QUEUE_DEPTH-1:0] i_hits,
    output logic                  o_done,
    output logic                  o_hit
);

    localparam int NCHUNK = (QUEUE_DEPTH + DCF_SCAN_CHUNK - 1) / DCF_SCAN_CHUNK;
    localparam int PAD_W  = NCHUNK * DCF_SCAN_CHUNK;
    localparam int IDX_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    logic [PAD_W-1:0] w_padded;
    logic [IDX_W-1:0] r_idx;
    logic             r_busy;
    logic             r_done;
    logic             r_acc;
    logic             w_last;

    assign w_padded = PAD_W'(i_hits);
    assign w_last   = (r_idx == IDX_W'(NCHUNK - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
            r_acc  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_acc  <= 1'b0;
            end else if (r_busy) begin
                r_acc <= r_acc | (|w_padded[r_idx * DCF_SCAN_CHUNK +: DCF_SCAN_CHUNK]);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_hit  = r_acc;

endmodule

`default_nettype wire

### rtl/dedup_coordinate_fifo.sv
// Top level of the duplicate-free coordinate queue: request control, cell chain,
// match scan and result register. Depends on dcf_pkg, dcf_if, dcf_cell, dcf_scan.
//
// A first-in first-out queue of (x, y) pairs that never stores the same pair
// twice. The pairs live in a chain of QUEUE_DEPTH cells with the oldest pair in
// cell zero; a pop moves every cell down by one and an add fills the first free
// cell. One request is handled at a time. Pop and clear go from acceptance
// straight to the result register. Add and contains first compare every
// cell against the pair, then fold the match flags 32 cells a cycle, and
// only then write the result register. A waiting result does not block the
// next request from being accepted; it only holds that request back until
// the result has been taken. Coordinates are reduced to their low
// COORD_WIDTH bits before use.
`default_nettype none

module dedup_coordinate_fifo
    import dcf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DCF_QUEUE_DEPTH,
    parameter int COORD_WIDTH = DCF_COORD_WIDTH
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    dcf_req_if.sink      i_req,
    dcf_res_if.source    o_res
);

    localparam int EW    = (COORD_WIDTH < DCF_FIELD_W) ? COORD_WIDTH : DCF_FIELD_W;
    localparam int KEY_W = 2 * EW;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_WAIT = 4'b0100,
        S_EXEC = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    t_op              r_op;
    logic [KEY_W-1:0] r_key;
    logic             r_hit;
    logic [CNT_W-1:0] r_count, n_count;

    logic             r_out_valid;
    t_status          r_out_status, n_status;
    logic             r_out_found, n_found;
    logic [EW-1:0]    r_out_x, r_out_y, n_x, n_y;
    logic [CNT_W-1:0] r_out_count;

    t_cell_ctrl       w_ctrl;
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_hits;
    logic [KEY_W-1:0] w_data [QUEUE_DEPTH];
    logic             w_scan_done, w_scan_hit;
    logic             w_accept, w_out_free, w_exec;
    logic             w_full, w_empty;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_exec      = (r_state == S_EXEC) && w_out_free;
    assign w_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty     = (r_count == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req.operation == OP_ADD || i_req.operation == OP_CONTAINS)
                              ? S_CMP : S_EXEC;
                end
            end
            S_CMP:  n_state = S_WAIT;
            S_WAIT: if (w_scan_done) n_state = S_EXEC;
            S_EXEC: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Decide the outcome of the held request and the matching cell action.
    always_comb begin
        w_ctrl   = '0;
        n_count  = r_count;
        n_status = ST_DONE;
        n_found  = 1'b0;
        n_x      = '0;
        n_y      = '0;
        w_ctrl.cmp = (r_state == S_CMP);
        unique case (r_op)
            OP_ADD: begin
                if (r_hit) begin
                    n_status = ST_DUP;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.load = w_exec;
                    n_count     = r_count + 1'b1;
                end
            end
            OP_POP: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctrl.shift = w_exec;
                    n_x          = w_data[0][KEY_W-1:EW];
                    n_y          = w_data[0][EW-1:0];
                    n_count      = r_count - 1'b1;
                end
            end
            OP_CONTAINS: n_found = r_hit;
            OP_CLEAR: begin
                w_ctrl.clear = w_exec;
                n_count      = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_req.operation;
            r_key <= {i_req.coord_x[EW-1:0], i_req.coord_y[EW-1:0]};
        end
        if (w_accept) begin
            r_hit <= 1'b0;
        end else if (w_scan_done) begin
            r_hit <= w_scan_hit;
        end
        if (w_exec) begin
            r_out_status <= n_status;
            r_out_found  <= n_found;
            r_out_x      <= n_x;
            r_out_y      <= n_y;
            r_out_count  <= n_count;
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic             w_prev_valid;
        logic             w_next_valid;
        logic [KEY_W-1:0] w_next_data;

        if (i == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_valid[i-1];
        end
        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_data  = '0;
        end else begin : g_link
            assign w_next_valid = w_valid[i+1];
            assign w_next_data  = w_data[i+1];
        end

        dcf_cell #(
            .KEY_W (KEY_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_key        (r_key),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_data  (w_next_data),
            .o_valid      (w_valid[i]),
            .o_data       (w_data[i]),
            .o_hit        (w_hits[i])
        );
    end

    dcf_scan #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctrl.cmp),
        .i_hits  (w_hits),
        .o_done  (w_scan_done),
        .o_hit   (w_scan_hit)
    );

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.found       = r_out_found;
    assign o_res.popped_x    = DCF_FIELD_W'(r_out_x);
    assign o_res.popped_y    = DCF_FIELD_W'(r_out_y);
    assign o_res.entry_count = r_out_count;
    assign o_res.is_empty    = (r_out_count == '0);

    // The count must always agree with the number of occupied cells.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(w_valid)))
        else $error("stored count disagrees with occupied cells");

    // The match scan only finishes while the controller is waiting for it.
    a_scan_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_done |-> r_state == S_WAIT)
        else $error("match scan finished outside the wait state");

    // A new result is only ever produced from the execute state.
    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result appeared without an execute step");

    // A pop on an empty queue must report an empty queue.
    a_empty_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_EMPTY) |-> o_res.entry_count == '0)
        else $error("empty pop reported a non-zero count");

endmodule

`default_nettype wire

### tb/sv/tb_dedup_coordinate_fifo.sv
// Self-checking testbench for the duplicate-free coordinate queue dedup_coordinate_fifo.
// Drives add, pop, contains and clear requests and predicts every result in a model of
// its own. Depends on dcf_pkg, the dcf_req_if/dcf_res_if interfaces and the block.
module tb_dedup_coordinate_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    import dcf_pkg::*;

    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_OFF_CYCLES = 300;
    // Watchdog limit that ends the run as failed if it is reached.
    localparam int CYCLE_LIMIT = 400000;
    localparam int unsigned COORD_MASK = (1 << DCF_COORD_WIDTH) - 1;

    typedef struct {
        t_op              op;
        logic [7:0]       x;
        logic [7:0]       y;
        bit               drain_first;
    } t_queue_req;

    typedef struct packed {
        t_status                status;
        logic                   found;
        logic [7:0]             px;
        logic [7:0]             py;
        logic [DCF_CNT_W-1:0]   count;
        logic                   empty;
    } t_queue_result;

    logic i_clk;
    logic i_rst_n;

    dcf_req_if req_if ();
    dcf_res_if res_if ();

    dedup_coordinate_fifo dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Shadow copy of the queue contents.
    int unsigned   slot_pair [DCF_QUEUE_DEPTH];
    bit            slot_used [DCF_QUEUE_DEPTH];
    int            head_idx;
    int            tail_idx;
    int            occupancy;

    t_queue_req    pending_reqs[$];
    t_queue_result expected_results[$];
    logic [15:0]   recent_pairs[$];

    int            n_total;
    int            n_sent;
    int            n_accepted;
    int            hold_cycles;
    bit            hold_done;
    int            mismatch_count;
    int            cycle_count;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic t_queue_result apply_queue_op(t_op op, logic [7:0] x, logic [7:0] y);
        t_queue_result r;
        int unsigned   key;
        int unsigned   cx;
        int unsigned   cy;
        bit            hit;
        int            i;
        cx = x & COORD_MASK;
        cy = y & COORD_MASK;
        key = (cx << DCF_COORD_WIDTH) | cy;
        r = '0;
        r.status = ST_DONE;
        hit = 1'b0;
        for (i = 0; i < DCF_QUEUE_DEPTH; i++) begin
            if (slot_used[i] && slot_pair[i] == key) hit = 1'b1;
        end
        case (op)
            OP_ADD: begin
                if (hit) begin
                    r.status = ST_DUP;
                end else if (occupancy >= DCF_QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot_pair[tail_idx] = key;
                    slot_used[tail_idx] = 1'b1;
                    tail_idx = (tail_idx + 1) % DCF_QUEUE_DEPTH;
                    occupancy++;
                end
            end
            OP_POP: begin
                if (occupancy == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.px = 8'((slot_pair[head_idx] >> DCF_COORD_WIDTH) & COORD_MASK);
                    r.py = 8'(slot_pair[head_idx] & COORD_MASK);
                    slot_used[head_idx] = 1'b0;
                    head_idx = (head_idx + 1) % DCF_QUEUE_DEPTH;
                    occupancy--;
                end
            end
            OP_CONTAINS: begin
                r.found = hit;
            end
            default: begin
                for (i = 0; i < DCF_QUEUE_DEPTH; i++) slot_used[i] = 1'b0;
                head_idx = 0;
                tail_idx = 0;
                occupancy = 0;
            end
        endcase
        r.count = occupancy[DCF_CNT_W-1:0];
        r.empty = (occupancy == 0);
        return r;
    endfunction

    task automatic push_req(input t_op op, input logic [7:0] x, input logic [7:0] y,
                            input bit drain_first);
        pending_reqs.push_back('{op, x, y, drain_first});
        if (op == OP_ADD) begin
            recent_pairs.push_back({x, y});
            if (recent_pairs.size() > 96) void'(recent_pairs.pop_front());
        end
    endtask

    function automatic logic [15:0] pick_pair(bit from_recent);
        if (from_recent && recent_pairs.size() > 0)
            return recent_pairs[$urandom_range(recent_pairs.size() - 1)];
        return 16'($urandom);
    endfunction

    function automatic int sender_idle_pct();
        if (n_sent < n_total / 3) return 33;
        if (n_sent < 2 * n_total / 3) return 61;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (n_sent < n_total / 3) return 61;
        if (n_sent < 2 * n_total / 3) return 33;
        return 0;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_result();
        t_queue_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with no request outstanding");
            return;
        end
        want = expected_results.pop_front();
        if (res_if.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", res_if.status, want.status));
        if (res_if.found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", res_if.found, want.found));
        if (res_if.popped_x !== want.px)
            report_mismatch($sformatf("popped_x %0h, expected %0h", res_if.popped_x, want.px));
        if (res_if.popped_y !== want.py)
            report_mismatch($sformatf("popped_y %0h, expected %0h", res_if.popped_y, want.py));
        if (res_if.entry_count !== want.count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      res_if.entry_count, want.count));
        if (res_if.is_empty !== want.empty)
            report_mismatch($sformatf("is_empty %0b, expected %0b", res_if.is_empty, want.empty));
    endtask

    // Request driver: predicts each request as it is accepted, then offers the next one.
    always @(posedge i_clk) begin
        t_queue_req next_req;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_results.push_back(apply_queue_op(req_if.operation, req_if.coord_x,
                                                          req_if.coord_y));
                n_accepted++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_reqs.size() > 0
                        && (!pending_reqs[0].drain_first || expected_results.size() == 0)
                        && $urandom_range(99) >= sender_idle_pct()) begin
                    next_req = pending_reqs.pop_front();
                    req_if.valid     <= 1'b1;
                    req_if.operation <= next_req.op;
                    req_if.coord_x   <= next_req.x;
                    req_if.coord_y   <= next_req.y;
                    n_sent <= n_sent + 1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) check_result();
            res_if.ready <= (hold_cycles == 0) && ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // One long receiver hold-off half way through, so the block backs up onto its input.
    always @(posedge i_clk) begin
        if (!hold_done && i_rst_n && n_sent == n_total / 2) begin
            hold_cycles <= HOLD_OFF_CYCLES;
            hold_done   <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int          n_directed;
        int          kind;
        int          n;
        int          i;
        logic [15:0] pair;

        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operation = OP_ADD;
        req_if.coord_x   = '0;
        req_if.coord_y   = '0;
        res_if.ready     = 1'b0;
        head_idx         = 0;
        tail_idx         = 0;
        occupancy        = 0;
        n_sent           = 0;
        n_accepted       = 0;
        hold_cycles      = 0;
        hold_done        = 1'b0;
        mismatch_count   = 0;
        cycle_count      = 0;
        for (i = 0; i < DCF_QUEUE_DEPTH; i++) begin
            slot_pair[i] = 0;
            slot_used[i] = 1'b0;
        end

        // Directed part: empty pop, extremes, duplicates, hits and misses, clear.
        push_req(OP_POP,      8'h00, 8'h00, 1'b0);
        push_req(OP_CONTAINS, 8'h00, 8'h00, 1'b0);
        push_req(OP_ADD,      8'h00, 8'h00, 1'b0);
        push_req(OP_ADD,      8'hff, 8'hff, 1'b0);
        push_req(OP_ADD,      8'h00, 8'h00, 1'b0);
        push_req(OP_CONTAINS, 8'hff, 8'hff, 1'b0);
        push_req(OP_CONTAINS, 8'hff, 8'h00, 1'b0);
        push_req(OP_CONTAINS, 8'h00, 8'hff, 1'b0);
        push_req(OP_ADD,      8'haa, 8'h55, 1'b0);
        push_req(OP_ADD,      8'h55, 8'haa, 1'b0);
        push_req(OP_POP,      8'hff, 8'hff, 1'b0);
        push_req(OP_CONTAINS, 8'h00, 8'h00, 1'b0);
        push_req(OP_ADD,      8'h00, 8'h00, 1'b0);
        push_req(OP_POP,      8'h12, 8'h34, 1'b0);
        push_req(OP_CLEAR,    8'hff, 8'hff, 1'b0);
        push_req(OP_POP,      8'h00, 8'h00, 1'b0);
        push_req(OP_CONTAINS, 8'h55, 8'haa, 1'b0);
        push_req(OP_ADD,      8'h01, 8'h02, 1'b0);
        push_req(OP_CLEAR,    8'h00, 8'h00, 1'b0);
        push_req(OP_ADD,      8'h01, 8'h02, 1'b0);
        push_req(OP_POP,      8'h00, 8'h00, 1'b0);
        push_req(OP_POP,      8'h00, 8'h00, 1'b0);
        n_directed = pending_reqs.size();

        // Random part: half the groups fill or drain the queue, so the full queue and pointer
        // wrap are reached often, with mixed traffic and noise in between.
        while (pending_reqs.size() < n_directed + RANDOM_ITEMS) begin
            kind = $urandom_range(9);
            case (kind)
                0, 1, 2: begin
                    if ($urandom_range(1)) push_req(OP_CLEAR, 8'($urandom), 8'($urandom), 1'b0);
                    n = $urandom_range(72, 62);
                    for (i = 0; i < n; i++) begin
                        pair = pick_pair($urandom_range(7) == 0);
                        push_req(OP_ADD, pair[15:8], pair[7:0], 1'b0);
                    end
                    // Adds against a queue that is probably full: new pairs and stored ones.
                    for (i = 0; i < 6; i++) begin
                        pair = pick_pair(i[0]);
                        push_req(OP_ADD, pair[15:8], pair[7:0], 1'b0);
                    end
                end
                3, 4: begin
                    push_req(OP_POP, 8'($urandom), 8'($urandom), 1'b1);
                    n = $urandom_range(70, 8);
                    for (i = 0; i < n; i++) begin
                        if ($urandom_range(5) == 0) begin
                            pair = pick_pair(1'b1);
                            push_req(OP_CONTAINS, pair[15:8], pair[7:0], 1'b0);
                        end else begin
                            push_req(OP_POP, 8'($urandom), 8'($urandom), 1'b0);
                        end
                    end
                end
                5, 6: begin
                    for (i = 0; i < 24; i++) begin
                        n = $urandom_range(99);
                        pair = pick_pair($urandom_range(1));
                        if (n < 40)      push_req(OP_ADD, pair[15:8], pair[7:0], 1'b0);
                        else if (n < 65) push_req(OP_POP, pair[15:8], pair[7:0], 1'b0);
                        else if (n < 95) push_req(OP_CONTAINS, pair[15:8], pair[7:0], 1'b0);
                        else             push_req(OP_CLEAR, pair[15:8], pair[7:0], 1'b0);
                    end
                end
                7: begin
                    // A tiny coordinate range makes duplicates the common case.
                    push_req(OP_CLEAR, 8'($urandom), 8'($urandom), 1'b0);
                    for (i = 0; i < 20; i++) begin
                        push_req($urandom_range(2) == 0 ? OP_CONTAINS : OP_ADD,
                                 8'($urandom_range(3)), 8'($urandom_range(3)), 1'b0);
                    end
                end
                8: begin
                    for (i = 0; i < 12; i++) begin
                        pair = pick_pair($urandom_range(2) != 0);
                        push_req(OP_CONTAINS, pair[15:8], pair[7:0], 1'b0);
                    end
                end
                default: begin
                    for (i = 0; i < 10; i++) begin
                        push_req(t_op'($urandom_range(3)), 8'($urandom), 8'($urandom), 1'b0);
                    end
                end
            endcase
        end
        // Make sure the sender pauses for a full drain at least once.
        pending_reqs[n_directed].drain_first = 1'b1;
        n_total = pending_reqs.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### dedup_coordinate_fifo.f
rtl/dcf_pkg.sv
rtl/dcf_if.sv
rtl/dcf_cell.sv
rtl/dcf_scan.sv
rtl/dedup_coordinate_fifo.sv
tb/sv/tb_dedup_coordinate_fifo.sv
